FILE: src/gtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared constants for the collection trigger policy unit:
// command and action codes, field widths, parameter defaults and ratios.
// ----------------------------------------------------------------------------
package gtp_pkg;

  // Field widths of the item channels
  localparam int CMD_W       = 3;
  localparam int ACT_W       = 2;
  localparam int TOTAL_IN_W  = 48;
  localparam int SLOT_W      = 32;
  localparam int PAGE_W      = 20;
  localparam int OBJ_W       = 32;
  localparam int CNT_OUT_W   = 32;
  localparam int SPP_W       = 16;

  // Peak growth storage, wide enough for the largest cap
  localparam int PEAK_W      = 18;

  // Parameter defaults
  localparam int TOTAL_WIDTH_DEF   = 48;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int PEAK_CAP_DEF      = 200000;

  // Reset value of slots per page
  localparam logic [SPP_W-1:0] SPP_RESET = 16'd408;

  // Fill ratio 0.97 as 100 * n >= 97 * limit
  localparam int RATIO_SCALE = 100;
  localparam int RATIO_FULL  = 97;
  // Major margin 0.98 as 50 * gap <= 49 * peak
  localparam int MAJ_SCALE   = 50;
  localparam int MAJ_MARGIN  = 49;

  // Commands
  localparam logic [CMD_W-1:0] CMD_GC_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_END  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP_END = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RUN       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MINOR_OUT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  // Actions
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SWEEP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MAJOR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_MINOR = 2'd3;

endpackage

FILE: src/gtp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_in_if
// Input item channel: valid/ready handshake with the event/run payload.
// ----------------------------------------------------------------------------
interface gtp_in_if
  import gtp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [TOTAL_IN_W-1:0] allocated_total;
  logic [SLOT_W-1:0]     swept_slots;
  logic [PAGE_W-1:0]     empty_pages;
  logic [SLOT_W-1:0]     final_slots;
  logic [OBJ_W-1:0]      old_objects;
  logic [OBJ_W-1:0]      old_limit;
  logic [OBJ_W-1:0]      shady_objects;
  logic [OBJ_W-1:0]      shady_limit;
  logic                  became_major;

  modport source (
    output valid, cmd, allocated_total, swept_slots, empty_pages, final_slots,
           old_objects, old_limit, shady_objects, shady_limit, became_major,
    input  ready
  );

  modport sink (
    input  valid, cmd, allocated_total, swept_slots, empty_pages, final_slots,
           old_objects, old_limit, shady_objects, shady_limit, became_major,
    output ready
  );
endinterface

FILE: src/gtp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_out_if
// Result item channel: valid/ready handshake with action and counters.
// ----------------------------------------------------------------------------
interface gtp_out_if
  import gtp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic                 enabled;
  logic [CNT_OUT_W-1:0] major_tally;
  logic [CNT_OUT_W-1:0] minor_tally;
  logic [CNT_OUT_W-1:0] sweep_tally;
  logic [CNT_OUT_W-1:0] total_count;

  modport source (
    output valid, action, enabled, major_tally, minor_tally, sweep_tally,
           total_count,
    input  ready
  );

  modport sink (
    input  valid, action, enabled, major_tally, minor_tally, sweep_tally,
           total_count,
    output ready
  );
endinterface

FILE: src/gc_trigger_policy_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_trigger_policy_unit
// Collection trigger policy: tracks collector events and allocation growth
// and answers sweep, major, minor or nothing for each run item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while ready is high and returns one result
// item for each, in order, through the stage 1 register and the output register.
// The first stage updates the policy state (pending sweep, allocation limit,
// growth mean and peak) on acceptance, so a following item sees it at once;
// the second stage makes the major/minor decision from registered gap,
// mean and peak and updates the counters into the output register. Throughput
// is one item per cycle; ready only drops while the output register is full
// and not being taken.
module gc_trigger_policy_unit
  import gtp_pkg::*;
#(
  parameter int TOTAL_WIDTH   = TOTAL_WIDTH_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
  parameter int PEAK_CAP      = PEAK_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [SPP_W-1:0] cfg_wdata,
  gtp_in_if.sink           in_ch,
  gtp_out_if.source        out_ch
);

  localparam int TW = TOTAL_WIDTH;
  localparam int CW = COUNTER_WIDTH;
  localparam int RW = OBJ_W + 7;        // 100 * 32-bit value
  localparam int MW = PEAK_W + 6;       // 50 * peak-range value
  localparam int PW = PAGE_W + SPP_W;   // pages * slots per page

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic out_free, s1_adv, in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // --------------------------------------------------------------------------
  // Policy state
  // --------------------------------------------------------------------------
  logic [SPP_W-1:0]  spp_r;
  logic              armed_r, armed_nxt;
  logic              pending_r, pending_nxt;
  logic [TW-1:0]     prev_r, prev_nxt;
  logic [TW-1:0]     budget_r, budget_nxt;
  logic [TW-1:0]     tas_r, tas_nxt;
  logic [TW-1:0]     mean_r, mean_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;

  // Stage 1 arithmetic on the incoming item
  logic [TW-1:0] total, delta, quarter, blend, peak_max, budget_calc, gap;
  logic [3:0]    rem3;
  logic [PW-1:0] page_slots;
  logic          first, total_ge, old_full, shady_full;

  assign total    = TW'(in_ch.allocated_total);
  assign delta    = total - prev_r;
  assign first    = (prev_r == '0);
  assign total_ge = (total >= budget_r);
  assign gap      = budget_r - total;

  // quarter-weight mean: d/4 + 3m/4 computed as floor pieces
  assign quarter = mean_r >> 2;
  assign rem3    = {2'b00, mean_r[1:0]} + {1'b0, mean_r[1:0], 1'b0};
  assign blend   = (delta >> 2) + quarter + (quarter << 1) + TW'(rem3[3:2]);

  // peak raised to the growth, then capped
  assign peak_max = (delta > TW'(peak_r)) ? delta : TW'(peak_r);

  // limit after sweep: start total + swept + empty page slots - final slots
  assign page_slots  = PW'(in_ch.empty_pages) * PW'(spp_r);
  assign budget_calc = tas_r + TW'(in_ch.swept_slots) + TW'(page_slots)
                       - TW'(in_ch.final_slots);

  // 97 percent fill tests
  assign old_full   = (RW'(in_ch.old_objects) * RW'(RATIO_SCALE))
                      >= (RW'(in_ch.old_limit) * RW'(RATIO_FULL));
  assign shady_full = (RW'(in_ch.shady_objects) * RW'(RATIO_SCALE))
                      >= (RW'(in_ch.shady_limit) * RW'(RATIO_FULL));

  // next state of the policy
  always_comb begin
    armed_nxt   = armed_r;
    pending_nxt = pending_r;
    prev_nxt    = prev_r;
    budget_nxt  = budget_r;
    tas_nxt     = tas_r;
    mean_nxt    = mean_r;
    peak_nxt    = peak_r;
    if (in_fire) begin
      case (in_ch.cmd)
        CMD_GC_START: begin
          if (armed_r) begin
            budget_nxt = '0;
            tas_nxt    = total;
          end
        end
        CMD_MARK_END: begin
          if (armed_r) begin
            pending_nxt = 1'b1;
          end
        end
        CMD_SWEEP_END: begin
          if (armed_r) begin
            pending_nxt = 1'b0;
            budget_nxt  = budget_calc;
          end
        end
        CMD_RUN: begin
          armed_nxt = 1'b1;
          prev_nxt  = total;
          if (!first) begin
            mean_nxt = (mean_r != '0) ? blend : delta;
            peak_nxt = (peak_max > TW'(PEAK_CAP)) ? PEAK_W'(PEAK_CAP)
                                                  : PEAK_W'(peak_max);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r     <= SPP_RESET;
      armed_r   <= 1'b0;
      pending_r <= 1'b0;
      prev_r    <= '0;
      budget_r  <= '0;
      tas_r     <= '0;
      mean_r    <= '0;
      peak_r    <= '0;
    end else begin
      if (cfg_we) begin
        spp_r <= cfg_wdata;
      end
      armed_r   <= armed_nxt;
      pending_r <= pending_nxt;
      prev_r    <= prev_nxt;
      budget_r  <= budget_nxt;
      tas_r     <= tas_nxt;
      mean_r    <= mean_nxt;
      peak_r    <= peak_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register: decision inputs for the accepted item
  // --------------------------------------------------------------------------
  logic [CMD_W-1:0]  s1_cmd_r;
  logic              s1_became_r, s1_enabled_r, s1_pending_r, s1_budget_nz_r;
  logic              s1_ge_r, s1_full_r;
  logic [TW-1:0]     s1_gap_r, s1_mean_r;
  logic [PEAK_W-1:0] s1_peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r       <= in_ch.cmd;
      s1_became_r    <= in_ch.became_major;
      s1_enabled_r   <= armed_nxt;
      s1_pending_r   <= pending_r;
      s1_budget_nz_r <= (budget_r != '0);
      s1_ge_r        <= total_ge;
      s1_full_r      <= old_full || shady_full;
      s1_gap_r       <= gap;
      s1_mean_r      <= mean_nxt;
      s1_peak_r      <= peak_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: major/minor decision and counters
  // --------------------------------------------------------------------------
  logic          gap_le_peak, maj_margin_ok, major_due, minor_due;
  logic [MW-1:0] maj_lhs, maj_rhs;

  assign gap_le_peak   = (s1_gap_r <= TW'(s1_peak_r));
  assign maj_lhs       = MW'(s1_gap_r[PEAK_W-1:0]) * MW'(MAJ_SCALE);
  assign maj_rhs       = MW'(s1_peak_r) * MW'(MAJ_MARGIN);
  assign maj_margin_ok = gap_le_peak && (maj_lhs <= maj_rhs);
  assign major_due     = s1_ge_r || maj_margin_ok;
  assign minor_due     = s1_ge_r || (s1_gap_r <= s1_mean_r);

  logic [CW-1:0]    major_r, major_nxt;
  logic [CW-1:0]    minor_r, minor_nxt;
  logic [CW-1:0]    sweep_r, sweep_nxt;
  logic [CW-1:0]    cnt_sum;
  logic [ACT_W-1:0] act_nxt;

  always_comb begin
    major_nxt = major_r;
    minor_nxt = minor_r;
    sweep_nxt = sweep_r;
    act_nxt   = ACT_NONE;
    case (s1_cmd_r)
      CMD_RUN: begin
        if (s1_pending_r) begin
          act_nxt   = ACT_SWEEP;
          sweep_nxt = sweep_r + CW'(1);
        end else if (s1_budget_nz_r) begin
          if (s1_full_r && major_due) begin
            act_nxt   = ACT_MAJOR;
            major_nxt = major_r + CW'(1);
          end else if (minor_due) begin
            act_nxt = ACT_MINOR;
          end
        end
      end
      CMD_MINOR_OUT: begin
        if (s1_became_r) begin
          major_nxt = major_r + CW'(1);
        end else begin
          minor_nxt = minor_r + CW'(1);
        end
      end
      CMD_CLEAR: begin
        major_nxt = '0;
        minor_nxt = '0;
        sweep_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cnt_sum = major_nxt + minor_nxt + sweep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
      sweep_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        major_r <= major_nxt;
        minor_r <= minor_nxt;
        sweep_r <= sweep_nxt;
      end
    end
  end

  // result register
  logic [ACT_W-1:0]     res_action_r;
  logic                 res_enabled_r;
  logic [CNT_OUT_W-1:0] res_major_r, res_minor_r, res_sweep_r, res_total_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_action_r  <= act_nxt;
      res_enabled_r <= s1_enabled_r;
      res_major_r   <= CNT_OUT_W'(major_nxt);
      res_minor_r   <= CNT_OUT_W'(minor_nxt);
      res_sweep_r   <= CNT_OUT_W'(sweep_nxt);
      res_total_r   <= CNT_OUT_W'(cnt_sum);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = res_action_r;
  assign out_ch.enabled     = res_enabled_r;
  assign out_ch.major_tally = res_major_r;
  assign out_ch.minor_tally = res_minor_r;
  assign out_ch.sweep_tally = res_sweep_r;
  assign out_ch.total_count = res_total_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // peak growth never exceeds its cap
  a_peak_capped: assert property (@(posedge clk) disable iff (!rst_n)
    TW'(peak_r) <= TW'(PEAK_CAP))
    else $error("peak growth above cap");

  // a limit can only be set once tracking is armed
  a_budget_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (budget_r != '0) |-> armed_r)
    else $error("allocation limit set while unarmed");

  // any trigger comes from an armed block
  a_action_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_action_r != ACT_NONE)) |-> res_enabled_r)
    else $error("action reported while not enabled");

  // enabled never drops from one result to the next
  a_enabled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.enabled) |=>
      (!out_ch.valid || out_ch.enabled))
    else $error("enabled dropped");

  // a stage 1 item is held until the output side takes it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> s1_valid_r)
    else $error("stage 1 item lost under stall");

endmodule

FILE: tb/sv/gc_trigger_policy_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_trigger_policy_unit_tb
// Self-checking bench for the collection trigger policy unit. Directed tests
// cover unarmed events, first growth samples, a full collection cycle, field
// extremes and the slots-per-page register. Random collection cycles with
// noise follow under several page sizes. A bit-accurate predictor produces
// the expected result item for every accepted input item.
// ----------------------------------------------------------------------------
module gc_trigger_policy_unit_tb;
  import gtp_pkg::*;

  // Commands the block decodes as no-ops
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [TOTAL_IN_W-1:0] allocated_total;
    logic [SLOT_W-1:0]     swept_slots;
    logic [PAGE_W-1:0]     empty_pages;
    logic [SLOT_W-1:0]     final_slots;
    logic [OBJ_W-1:0]      old_objects;
    logic [OBJ_W-1:0]      old_limit;
    logic [OBJ_W-1:0]      shady_objects;
    logic [OBJ_W-1:0]      shady_limit;
    logic                  became_major;
  } policy_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic                 enabled;
    logic [CNT_OUT_W-1:0] major_tally;
    logic [CNT_OUT_W-1:0] minor_tally;
    logic [CNT_OUT_W-1:0] sweep_tally;
    logic [CNT_OUT_W-1:0] total_count;
  } policy_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [SPP_W-1:0] cfg_wdata;

  gtp_in_if  in_ch ();
  gtp_out_if out_ch ();

  gc_trigger_policy_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [SPP_W-1:0]      pol_spp = SPP_RESET;
  logic                  pol_armed = 1'b0;
  logic                  pol_sweep_pending = 1'b0;
  logic [TOTAL_IN_W-1:0] pol_prev_total = '0;
  logic [TOTAL_IN_W-1:0] pol_budget = '0;
  logic [TOTAL_IN_W-1:0] pol_start_total = '0;
  logic [TOTAL_IN_W-1:0] pol_mean = '0;
  logic [PEAK_W-1:0]     pol_peak = '0;
  logic [CNT_OUT_W-1:0]  cnt_major = '0;
  logic [CNT_OUT_W-1:0]  cnt_minor = '0;
  logic [CNT_OUT_W-1:0]  cnt_sweep = '0;

  policy_result_t        pending_results[$];
  policy_result_t        head_res;
  logic [ACT_W-1:0]      last_action;
  logic [TOTAL_IN_W-1:0] heap_alloc;
  int                    n_items = 0;
  int                    n_errors = 0;
  int                    action_seen[4] = '{0, 0, 0, 0};
  bit                    idle_on = 1'b1;
  int                    stall_left = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Quarter-weight mean and capped peak of growth between run items
  function automatic void update_growth(input logic [TOTAL_IN_W-1:0] total);
    logic [TOTAL_IN_W-1:0] d;
    logic [TOTAL_IN_W-1:0] pk;
    if (pol_prev_total == '0) begin
      pol_prev_total = total;
      return;
    end
    d = total - pol_prev_total;
    pol_prev_total = total;
    if (pol_mean != '0)
      pol_mean = (d >> 2) + (pol_mean >> 2) * TOTAL_IN_W'(3)
                 + (((pol_mean & TOTAL_IN_W'(3)) * TOTAL_IN_W'(3)) >> 2);
    else
      pol_mean = d;
    pk = TOTAL_IN_W'(pol_peak);
    if (d > pk) pk = d;
    if (pk > TOTAL_IN_W'(PEAK_CAP_DEF)) pk = TOTAL_IN_W'(PEAK_CAP_DEF);
    pol_peak = pk[PEAK_W-1:0];
  endfunction

  function automatic bit major_due(input logic [TOTAL_IN_W-1:0] total);
    logic [63:0] gap;
    if (total >= pol_budget) return 1'b1;
    gap = 64'(pol_budget - total);
    if (gap > 64'(pol_peak)) return 1'b0;
    return gap * 64'(MAJ_SCALE) <= 64'(pol_peak) * 64'(MAJ_MARGIN);
  endfunction

  function automatic bit minor_due(input logic [TOTAL_IN_W-1:0] total);
    if (total >= pol_budget) return 1'b1;
    return (pol_budget - total) <= pol_mean;
  endfunction

  function automatic bit ratio_full(input logic [OBJ_W-1:0] n, input logic [OBJ_W-1:0] lim);
    return 64'(n) * 64'(RATIO_SCALE) >= 64'(lim) * 64'(RATIO_FULL);
  endfunction

  function automatic policy_result_t predict_policy(input policy_item_t it);
    policy_result_t r;
    r.action = ACT_NONE;
    case (it.cmd)
      CMD_GC_START: begin
        if (pol_armed) begin
          pol_budget = '0;
          pol_start_total = it.allocated_total;
        end
      end
      CMD_MARK_END: begin
        if (pol_armed) pol_sweep_pending = 1'b1;
      end
      CMD_SWEEP_END: begin
        if (pol_armed) begin
          pol_sweep_pending = 1'b0;
          pol_budget = pol_start_total + TOTAL_IN_W'(it.swept_slots)
                       + TOTAL_IN_W'(it.empty_pages) * TOTAL_IN_W'(pol_spp)
                       - TOTAL_IN_W'(it.final_slots);
        end
      end
      CMD_RUN: begin
        pol_armed = 1'b1;
        update_growth(it.allocated_total);
        if (pol_sweep_pending) begin
          cnt_sweep++;
          r.action = ACT_SWEEP;
        end else if (pol_budget != '0) begin
          if ((ratio_full(it.old_objects, it.old_limit) ||
               ratio_full(it.shady_objects, it.shady_limit)) &&
              major_due(it.allocated_total)) begin
            cnt_major++;
            r.action = ACT_MAJOR;
          end else if (minor_due(it.allocated_total)) begin
            r.action = ACT_MINOR;
          end
        end
      end
      CMD_MINOR_OUT: begin
        if (it.became_major) cnt_major++;
        else cnt_minor++;
      end
      CMD_CLEAR: begin
        cnt_major = '0;
        cnt_minor = '0;
        cnt_sweep = '0;
      end
      default: ;
    endcase
    r.enabled     = pol_armed;
    r.major_tally = cnt_major;
    r.minor_tally = cnt_minor;
    r.sweep_tally = cnt_sweep;
    r.total_count = cnt_major + cnt_minor + cnt_sweep;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Every field full-width random; tests override what matters
  function automatic policy_item_t random_item(input logic [CMD_W-1:0] cmd);
    policy_item_t it;
    it.cmd             = cmd;
    it.allocated_total = TOTAL_IN_W'({$urandom, $urandom});
    it.swept_slots     = $urandom;
    it.empty_pages     = PAGE_W'($urandom);
    it.final_slots     = $urandom;
    it.old_objects     = $urandom;
    it.old_limit       = $urandom;
    it.shady_objects   = $urandom;
    it.shady_limit     = $urandom;
    it.became_major    = 1'($urandom);
    return it;
  endfunction

  // Count and limit straddling the 0.97 fill ratio
  function automatic void near_ratio(output logic [OBJ_W-1:0] n, output logic [OBJ_W-1:0] lim);
    longint unsigned l;
    longint unsigned base;
    longint unsigned off;
    l    = 64'($urandom_range(0, 3000000));
    base = l * 64'(97) / 64'(100);
    off  = 64'($urandom_range(0, 3));
    lim  = OBJ_W'(l);
    n    = (base + off >= 2) ? OBJ_W'(base + off - 2) : '0;
  endfunction

  // Present one item, wait for acceptance, then record its expected result
  task automatic send_item(input policy_item_t it);
    bit taken;
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= it.cmd;
    in_ch.allocated_total <= it.allocated_total;
    in_ch.swept_slots     <= it.swept_slots;
    in_ch.empty_pages     <= it.empty_pages;
    in_ch.final_slots     <= it.final_slots;
    in_ch.old_objects     <= it.old_objects;
    in_ch.old_limit       <= it.old_limit;
    in_ch.shady_objects   <= it.shady_objects;
    in_ch.shady_limit     <= it.shady_limit;
    in_ch.became_major    <= it.became_major;
    // ready is stable from the negedge up to the next rising edge
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    head_res = predict_policy(it);
    last_action = head_res.action;
    action_seen[head_res.action]++;
    pending_results.push_back(head_res);
    n_items++;
  endtask

  // Idle the input and let every outstanding result come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_spp(input logic [SPP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    pol_spp = v;
  endtask

  task automatic send_run();
    policy_item_t it;
    int growth;
    growth = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400000)
                                         : $urandom_range(0, 40000);
    heap_alloc = heap_alloc + TOTAL_IN_W'(growth);
    it = random_item(CMD_RUN);
    it.allocated_total = heap_alloc;
    if ($urandom_range(0, 3) != 0) near_ratio(it.old_objects, it.old_limit);
    if ($urandom_range(0, 1) != 0) near_ratio(it.shady_objects, it.shady_limit);
    send_item(it);
  endtask

  // gc start, mark, up to two runs, sweep, then runs until a collection is asked for or the run budget ends
  task automatic run_cycle();
    policy_item_t it;
    int headroom;
    int n_runs;
    logic [SLOT_W-1:0] fin;
    it = random_item(CMD_GC_START);
    it.allocated_total = heap_alloc;
    send_item(it);
    send_item(random_item(CMD_MARK_END));
    repeat ($urandom_range(0, 2)) send_run();
    headroom = $urandom_range(0, 250000);
    fin      = $urandom_range(0, 5000);
    it = random_item(CMD_SWEEP_END);
    it.empty_pages = PAGE_W'($urandom_range(0, 3));
    it.final_slots = fin;
    it.swept_slots = SLOT_W'(headroom) + fin;
    send_item(it);
    n_runs = $urandom_range(2, 12);
    repeat (n_runs) begin
      send_run();
      if (last_action == ACT_MINOR && $urandom_range(0, 3) != 0)
        send_item(random_item(CMD_MINOR_OUT));
      if (last_action == ACT_MAJOR || last_action == ACT_MINOR) break;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls and checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Payload and handshake are stable at the negedge before the taking edge
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected item waiting");
        n_errors++;
      end else begin
        head_res = pending_results.pop_front();
        check_field("action", 32'(head_res.action), 32'(out_ch.action));
        check_field("enabled", 32'(head_res.enabled), 32'(out_ch.enabled));
        check_field("major_tally", head_res.major_tally, out_ch.major_tally);
        check_field("minor_tally", head_res.minor_tally, out_ch.minor_tally);
        check_field("sweep_tally", head_res.sweep_tally, out_ch.sweep_tally);
        check_field("total_count", head_res.total_count, out_ch.total_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Collector events are ignored before arming; counter items are not
  task automatic test_unarmed_events();
    policy_item_t it;
    it = random_item(CMD_GC_START);
    it.allocated_total = '1;
    send_item(it);
    send_item(random_item(CMD_MARK_END));
    it = random_item(CMD_SWEEP_END);
    it.swept_slots = '1;
    it.empty_pages = '1;
    it.final_slots = '0;
    send_item(it);
    it = random_item(CMD_MINOR_OUT);
    it.became_major = 1'b1;
    send_item(it);
    it.became_major = 1'b0;
    send_item(it);
    send_item(random_item(CMD_CLEAR));
    send_item(random_item(CMD_UNUSED_6));
    send_item(random_item(CMD_UNUSED_7));
  endtask

  // First run only stores the total, the second one gives a growth sample
  task automatic test_first_sample();
    policy_item_t it;
    it = random_item(CMD_RUN);
    it.allocated_total = TOTAL_IN_W'(1000);
    send_item(it);
    it.allocated_total = TOTAL_IN_W'(6000);
    send_item(it);
  endtask

  // Pending sweep, then budget with a major and a minor answer
  task automatic test_collection_cycle();
    policy_item_t it;
    it = random_item(CMD_GC_START);
    it.allocated_total = TOTAL_IN_W'(6000);
    send_item(it);
    send_item(random_item(CMD_MARK_END));
    it = random_item(CMD_RUN);
    it.allocated_total = TOTAL_IN_W'(9000);
    send_item(it);
    it = random_item(CMD_SWEEP_END);
    it.swept_slots = 20000;
    it.empty_pages = PAGE_W'(10);
    it.final_slots = 80;
    send_item(it);
    it = random_item(CMD_RUN);
    it.allocated_total = TOTAL_IN_W'(26000);
    it.old_objects     = 97;
    it.old_limit       = 100;
    send_item(it);
    it.allocated_total = TOTAL_IN_W'(27000);
    it.old_objects     = 96;
    it.shady_objects   = 0;
    it.shady_limit     = 1;
    send_item(it);
    it = random_item(CMD_MINOR_OUT);
    it.became_major = 1'b0;
    send_item(it);
  endtask

  // Largest total, wrap back to zero, then a fresh first sample
  task automatic test_field_extremes();
    policy_item_t it;
    it = random_item(CMD_RUN);
    it.allocated_total = '1;
    it.old_objects     = '1;
    it.old_limit       = '1;
    it.shady_objects   = '1;
    it.shady_limit     = '1;
    send_item(it);
    it.allocated_total = '0;
    send_item(it);
    it.allocated_total = TOTAL_IN_W'(5);
    send_item(it);
  endtask

  // Smallest and largest page size with full-scale sweep fields
  task automatic test_slot_config();
    policy_item_t it;
    drain_results();
    write_spp(16'd1);
    it = random_item(CMD_SWEEP_END);
    it.swept_slots = '1;
    it.empty_pages = '1;
    it.final_slots = '1;
    send_item(it);
    send_item(random_item(CMD_RUN));
    drain_results();
    write_spp(16'hFFFF);
    it = random_item(CMD_GC_START);
    it.allocated_total = 48'hFFFF_FFFF_F000;
    send_item(it);
    it = random_item(CMD_SWEEP_END);
    it.swept_slots = '1;
    it.empty_pages = '1;
    it.final_slots = '0;
    send_item(it);
    send_item(random_item(CMD_RUN));
  endtask

  // Mostly well-formed cycles, with noise and broken sequences mixed in
  task automatic test_random_traffic(input logic [SPP_W-1:0] spp, input int n_target);
    int stop_at;
    drain_results();
    write_spp(spp);
    heap_alloc = TOTAL_IN_W'({$urandom, $urandom});
    stop_at = n_items + n_target;
    while (n_items < stop_at) begin
      idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3))
             send_item(random_item(CMD_W'($urandom_range(0, 7))));
        1: begin
          if ($urandom_range(0, 2) == 0) send_item(random_item(CMD_CLEAR));
          else send_run();
        end
        default: run_cycle();
      endcase
    end
  endtask

  // Back-to-back items with both sides always ready
  task automatic test_steady_traffic(input int n_target);
    int stop_at;
    idle_on = 1'b0;
    stop_at = n_items + n_target;
    while (n_items < stop_at) run_cycle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_GC_START;
    in_ch.allocated_total = '0;
    in_ch.swept_slots     = '0;
    in_ch.empty_pages     = '0;
    in_ch.final_slots     = '0;
    in_ch.old_objects     = '0;
    in_ch.old_limit       = '0;
    in_ch.shady_objects   = '0;
    in_ch.shady_limit     = '0;
    in_ch.became_major    = 1'b0;
    out_ch.ready          = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unarmed_events();
    test_first_sample();
    test_collection_cycle();
    test_field_extremes();
    test_slot_config();
    test_random_traffic(16'($urandom_range(1, 65535)), 380);
    test_random_traffic(16'd1, 380);
    test_random_traffic(16'hFFFF, 380);
    test_random_traffic(SPP_RESET, 380);
    test_random_traffic(16'($urandom_range(1, 1000)), 250);
    test_steady_traffic(200);
    drain_results();

    $display("Covered %0d items across several page sizes, with and without stalls",
             n_items);
    $display("Actions seen: %0d none, %0d sweep, %0d major, %0d minor",
             action_seen[ACT_NONE], action_seen[ACT_SWEEP],
             action_seen[ACT_MAJOR], action_seen[ACT_MINOR]);
    if (n_errors == 0) begin
      $display("gc_trigger_policy_unit_tb OK");
    end else begin
      $display("gc_trigger_policy_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("gc_trigger_policy_unit_tb NOT OK");
    $finish;
  end

endmodule

FILE: gc_trigger_policy_unit.f
src/gtp_pkg.sv
src/gtp_in_if.sv
src/gtp_out_if.sv
src/gc_trigger_policy_unit.sv
tb/sv/gc_trigger_policy_unit_tb.sv
